FILE: rtl/c2r_pkg.sv
// constants and entry codes for the cayley vector to rotation matrix pipeline
package c2r_pkg;

    // input format: signed fixed point with IN_FRAC_BITS fraction bits
    localparam int IN_W          = 16;
    localparam int IN_FRAC_BITS  = 12;
    localparam int PROD_W        = 2 * IN_W;

    // output format: signed q1.14
    localparam int OUT_W         = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int OUT_ONE       = 1 << OUT_FRAC_BITS;

    // divisor s = 1 + x^2 + y^2 + z^2 is unsigned, numerators carry a sign
    localparam int S_W   = ((2 * IN_FRAC_BITS > PROD_W) ? 2 * IN_FRAC_BITS : PROD_W) + 1;
    localparam int NUM_W = S_W + 1;

    // quotient bits, one per divider stage, and the partial remainder width
    localparam int QB  = OUT_FRAC_BITS + 1;
    localparam int R_W = S_W + QB + 1;

    // products, numerators, divider setup, divider bits, output register
    localparam int NSTG = QB + 4;

    localparam int NUM_ENT = 9;

    localparam int S_TDATA_W = ((3 * IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((NUM_ENT * OUT_W + 7) / 8) * 8;

    // matrix entry positions, row major
    localparam int E_00 = 0;
    localparam int E_01 = 1;
    localparam int E_02 = 2;
    localparam int E_10 = 3;
    localparam int E_11 = 4;
    localparam int E_12 = 5;
    localparam int E_20 = 6;
    localparam int E_21 = 7;
    localparam int E_22 = 8;

endpackage

FILE: rtl/cayley_to_rotation.sv
// cayley vector to 3x3 rotation matrix, fully pipelined with restoring dividers
//
//  channel   dir   ports                          beat contents
//  s_        in    s_tvalid s_tready s_tdata      cay_x, cay_y, cay_z
//  m_        out   m_tvalid m_tready m_tdata      rot_00 .. rot_22 row major
//
// one vector per cycle sustained while the master side accepts; the nine restoring
// dividers retire one quotient bit per pipeline stage.
// reset clears only the stage valid bits; data registers are left as they are.
// a stall at the master side holds the last stage; each stage loads whenever it
// is empty or moving, so bubbles close up and input is taken while results wait.
module cayley_to_rotation
    import c2r_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // cay_x, cay_y, cay_z
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // rot_00, rot_01, rot_02, rot_10 .. rot_22
);

    localparam logic signed [NUM_W-1:0] ONE_Q = NUM_W'(1) << (2 * IN_FRAC_BITS);

    // stage control
    logic [NSTG-1:0] valid_reg, valid_next;
    logic [NSTG-1:0] rdy;

    // stage 0: products
    logic signed [IN_W-1:0]   in_x, in_y, in_z;
    logic signed [IN_W-1:0]   x_reg, y_reg, z_reg;
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;

    // stage 1: divisor and numerators
    logic signed [NUM_W-1:0] num_next [NUM_ENT];
    logic signed [NUM_W-1:0] num_reg  [NUM_ENT];
    logic        [S_W-1:0]   s_next, s_reg;

    // divider: index 0 is the setup stage, index k + 1 after quotient bit k
    logic [R_W-1:0] rem_reg  [QB+1][NUM_ENT];
    logic [R_W-1:0] rem_next [QB+1][NUM_ENT];
    logic [QB-1:0]  quo_reg  [QB+1][NUM_ENT];
    logic [QB-1:0]  quo_next [QB+1][NUM_ENT];
    logic           neg_reg  [QB+1][NUM_ENT];
    logic           neg_next [QB+1][NUM_ENT];
    logic [S_W-1:0] den_reg  [QB+1];
    logic [S_W-1:0] den_next [QB+1];

    // output stage
    logic [OUT_W-1:0] res_reg  [NUM_ENT];
    logic [OUT_W-1:0] res_next [NUM_ENT];

    assign in_x = s_tdata[IN_W-1:0];
    assign in_y = s_tdata[2*IN_W-1:IN_W];
    assign in_z = s_tdata[3*IN_W-1:2*IN_W];

    // ready ripples back: a stage can load if empty or its content moves on
    always_comb begin
        rdy[NSTG-1] = !valid_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next[0] = rdy[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[NSTG-1];

    // stage 1 logic: s and the nine numerators, all exact
    always_comb begin
        logic signed [NUM_W-1:0] sxx, syy, szz, sxy, sxz, syz, xs, ys, zs;
        sxx = NUM_W'(xx_reg);
        syy = NUM_W'(yy_reg);
        szz = NUM_W'(zz_reg);
        sxy = NUM_W'(xy_reg);
        sxz = NUM_W'(xz_reg);
        syz = NUM_W'(yz_reg);
        xs  = NUM_W'(x_reg) <<< IN_FRAC_BITS;
        ys  = NUM_W'(y_reg) <<< IN_FRAC_BITS;
        zs  = NUM_W'(z_reg) <<< IN_FRAC_BITS;

        s_next = S_W'(ONE_Q + sxx + syy + szz);

        num_next[E_00] = ONE_Q + sxx - syy - szz;
        num_next[E_01] = (sxy - zs) <<< 1;
        num_next[E_02] = (sxz + ys) <<< 1;
        num_next[E_10] = (sxy + zs) <<< 1;
        num_next[E_11] = ONE_Q - sxx + syy - szz;
        num_next[E_12] = (syz - xs) <<< 1;
        num_next[E_20] = (sxz - ys) <<< 1;
        num_next[E_21] = (syz + xs) <<< 1;
        num_next[E_22] = ONE_Q - sxx - syy + szz;
    end

    // divider setup and one quotient bit per stage
    always_comb begin
        logic [NUM_W-1:0] mag;
        logic [R_W-1:0]   dsh;
        int               bitpos;

        // dividend is |num| * 2^(OUT_FRAC_BITS+1) + s, divisor 2s; |num| never exceeds s
        den_next[0] = s_reg;
        for (int j = 0; j < NUM_ENT; j++) begin
            mag = num_reg[j][NUM_W-1] ? (NUM_W'(0) - num_reg[j]) : num_reg[j];
            neg_next[0][j] = num_reg[j][NUM_W-1];
            rem_next[0][j] = (R_W'(mag[S_W-1:0]) << QB) + R_W'(s_reg);
            quo_next[0][j] = '0;
        end

        for (int k = 0; k < QB; k++) begin
            bitpos = QB - 1 - k;
            den_next[k+1] = den_reg[k];
            dsh = R_W'(den_reg[k]) << (bitpos + 1);
            for (int j = 0; j < NUM_ENT; j++) begin
                neg_next[k+1][j] = neg_reg[k][j];
                if (rem_reg[k][j] >= dsh) begin
                    rem_next[k+1][j] = rem_reg[k][j] - dsh;
                    quo_next[k+1][j] = quo_reg[k][j] | (QB'(1) << bitpos);
                end else begin
                    rem_next[k+1][j] = rem_reg[k][j];
                    quo_next[k+1][j] = quo_reg[k][j];
                end
            end
        end
    end

    // saturate to plus or minus one and restore the sign
    always_comb begin
        logic [QB-1:0] sat;
        for (int j = 0; j < NUM_ENT; j++) begin
            sat = (quo_reg[QB][j] > QB'(OUT_ONE)) ? QB'(OUT_ONE) : quo_reg[QB][j];
            res_next[j] = neg_reg[QB][j] ? (OUT_W'(0) - OUT_W'(sat)) : OUT_W'(sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            x_reg  <= in_x;
            y_reg  <= in_y;
            z_reg  <= in_z;
            xx_reg <= in_x * in_x;
            yy_reg <= in_y * in_y;
            zz_reg <= in_z * in_z;
            xy_reg <= in_x * in_y;
            xz_reg <= in_x * in_z;
            yz_reg <= in_y * in_z;
        end
        if (rdy[1]) begin
            s_reg   <= s_next;
            num_reg <= num_next;
        end
        for (int k = 0; k <= QB; k++) begin
            if (rdy[k+2]) begin
                den_reg[k] <= den_next[k];
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                neg_reg[k] <= neg_next[k];
            end
        end
        if (rdy[NSTG-1]) begin
            res_reg <= res_next;
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int j = 0; j < NUM_ENT; j++) begin
            m_tdata[j*OUT_W +: OUT_W] = res_reg[j];
        end
    end

endmodule

FILE: tb/cayley_to_rotation_test.sv
// self-checking testbench for the cayley vector to rotation matrix pipeline
`timescale 1ns / 100ps

module cayley_to_rotation_test;
    import c2r_pkg::*;

    typedef struct packed {
        logic signed [IN_W-1:0] z;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] x;
    } cay_vec_t;

    typedef logic signed [OUT_W-1:0] q14_t;
    typedef q14_t [NUM_ENT-1:0] rot_mat_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;

    localparam int RAND_N         = 1500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIR_N          = 20;
    localparam int DIR_TYPED_N    = 5;

    localparam string ENT_NAME [NUM_ENT] = '{
        "rot_00", "rot_01", "rot_02", "rot_10", "rot_11",
        "rot_12", "rot_20", "rot_21", "rot_22"
    };

    // x, y, z per row; the first DIR_TYPED_N rows carry hand-written matrices
    int dir_vec [DIR_N][3] = '{
        '{0, 0, 0},
        '{4096, 0, 0},
        '{0, 4096, 0},
        '{0, 0, 4096},
        '{-4096, 0, 0},
        '{32767, 32767, 32767},
        '{-32768, -32768, -32768},
        '{32767, -32768, 0},
        '{-32768, 0, 32767},
        '{0, 0, -32768},
        '{1, 0, 0},
        '{0, -1, 0},
        '{0, 0, 1},
        '{1, 1, 1},
        '{-1, -1, -1},
        '{4096, 4096, 4096},
        '{2048, -2048, 2048},
        '{21845, -21846, 21845},
        '{-21846, 21845, -21846},
        '{32767, 0, -32768}
    };

    int dir_mat [DIR_TYPED_N][NUM_ENT] = '{
        '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384},
        '{16384, 0, 0, 0, 0, -16384, 0, 16384, 0},
        '{0, 0, 16384, 0, 16384, 0, -16384, 0, 0},
        '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384},
        '{16384, 0, 0, 0, 0, 16384, 0, -16384, 0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // cay_x, cay_y, cay_z
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;    // rot_00, rot_01, rot_02, rot_10 .. rot_22

    rot_mat_t pending_mats [$];
    int       n_sent;
    int       n_checked = 0;
    int       n_errors = 0;
    int       burst_left;
    int       idle_cycles = 0;
    int       rx_left = 0;
    int       cyc_cnt = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    cayley_to_rotation u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // round(num * 2^14 / den) with ties away from zero, clamped to +-1.0
    function automatic q14_t round_q14(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< (OUT_FRAC_BITS + 1)) + den) / (2 * den);
        if (q > OUT_ONE)
            q = OUT_ONE;
        return q14_t'((num < 0) ? -q : q);
    endfunction

    function automatic rot_mat_t rotation_of(input cay_vec_t v);
        longint x, y, z, one, unit, xx, yy, zz, xy, xz, yz, xs, ys, zs, s;
        rot_mat_t m;
        x = longint'(v.x);
        y = longint'(v.y);
        z = longint'(v.z);
        one = longint'(1) <<< (2 * IN_FRAC_BITS);
        unit = longint'(1) <<< IN_FRAC_BITS;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        xy = x * y;
        xz = x * z;
        yz = y * z;
        xs = x * unit;
        ys = y * unit;
        zs = z * unit;
        s = one + xx + yy + zz;
        m[E_00] = round_q14(one + xx - yy - zz, s);
        m[E_01] = round_q14(2 * (xy - zs), s);
        m[E_02] = round_q14(2 * (xz + ys), s);
        m[E_10] = round_q14(2 * (xy + zs), s);
        m[E_11] = round_q14(one - xx + yy - zz, s);
        m[E_12] = round_q14(2 * (yz - xs), s);
        m[E_20] = round_q14(2 * (xz - ys), s);
        m[E_21] = round_q14(2 * (yz + xs), s);
        m[E_22] = round_q14(one - xx - yy + zz, s);
        return m;
    endfunction

    function automatic logic signed [IN_W-1:0] rand_component();
        logic signed [IN_W-1:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2:    c = IN_W'($urandom);
            // within +-2.0, where most real rotations sit
            3, 4, 5, 6: c = IN_W'($urandom_range(0, 16383) - 8192);
            7:          c = IN_W'($urandom_range(0, 32) - 16);
            8:          c = IN_W'(1) << $urandom_range(0, IN_W - 1);
            default:    c = ~(IN_W'(1) << $urandom_range(0, IN_W - 1));
        endcase
        return c;
    endfunction

    // one beat on the input side, opening a random gap when a burst runs out
    task automatic send_vector(input cay_vec_t v, input bit typed, input rot_mat_t typed_mat);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_mats.push_back(typed ? typed_mat : rotation_of(v));
        n_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_mats.size() != 0) @(posedge aclk);
    endtask

    // receiver stall pattern: switches between a few modes every so often
    always @(negedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_SLOW:     m_tready <= ($urandom_range(0, 3) == 0);
            default:     m_tready <= ((cyc_cnt % 7) < 4);
        endcase
    end

    always @(posedge aclk) begin : check_results
        rot_mat_t got;
        rot_mat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_mats.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %h", $time, got);
                n_errors++;
            end else begin
                want = pending_mats.pop_front();
                n_checked++;
                for (int e = 0; e < NUM_ENT; e++) begin
                    if (got[e] !== want[e]) begin
                        $display("%0t: %s expected %0d got %0d", $time, ENT_NAME[e],
                                 $signed(want[e]), $signed(got[e]));
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, pending_mats.size());
                $display("cayley_to_rotation_test failed");
                $finish;
            end
        end
    end

    initial begin
        cay_vec_t v;
        rot_mat_t tm;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        burst_left = 0;
        n_sent     = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            v.x = IN_W'(dir_vec[i][0]);
            v.y = IN_W'(dir_vec[i][1]);
            v.z = IN_W'(dir_vec[i][2]);
            tm = '0;
            if (i < DIR_TYPED_N) begin
                for (int e = 0; e < NUM_ENT; e++)
                    tm[e] = q14_t'(dir_mat[i][e]);
            end
            send_vector(v, i < DIR_TYPED_N, tm);
        end
        drain();

        for (int i = 0; i < RAND_N; i++) begin
            // let the pipeline run dry once in the middle
            if (i == RAND_N / 2)
                drain();
            v.x = rand_component();
            v.y = rand_component();
            v.z = rand_component();
            send_vector(v, 1'b0, '0);
        end
        drain();
        repeat (3 * NSTG) @(posedge aclk);

        $display("run covered %0d vectors (%0d directed, %0d random) and checked %0d matrices",
                 n_sent, DIR_N, RAND_N, n_checked);
        if (n_errors == 0)
            $display("cayley_to_rotation_test passed");
        else
            $display("cayley_to_rotation_test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/c2r_pkg.sv
rtl/cayley_to_rotation.sv
tb/cayley_to_rotation_test.sv
